[design/emf_pkg.sv]
// emf_pkg: types, register indexes and helper functions for the
// exponent/mantissa frame codec. No dependencies.
`default_nettype none

package emf_pkg;

   // field widths
   localparam int FRAME_W = 16;
   localparam int CODE_W  = 8;
   localparam int CFG_W   = 3;

   // operation codes
   localparam logic REQ_ENCODE = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // register indexes
   localparam logic CSR_EXP_BITS  = 1'b0;
   localparam logic CSR_MANT_BITS = 1'b1;

   // register reset values
   localparam logic [CFG_W-1:0] EXP_BITS_RST  = 3'd2;
   localparam logic [CFG_W-1:0] MANT_BITS_RST = 3'd6;

   // effective field widths
   typedef struct packed {
      logic [CFG_W-1:0] exp_bits;
      logic [CFG_W-1:0] mant_bits;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic [CODE_W-1:0]  code_out;
      logic [FRAME_W-1:0] frame_out;
      logic               saturated;
      logic               code_error;
   } rsp_type;

   // exponent width clamped to 1..4 and to 8 - mantissa width
   function automatic logic [CFG_W-1:0] eff_exp(input logic [CFG_W-1:0] raw,
                                                input logic [CFG_W-1:0] mant);
      logic [CFG_W-1:0] eb;
      eb = raw;
      if (eb < 3'd1) eb = 3'd1;
      if (eb > 3'd4) eb = 3'd4;
      if (({1'b0, eb} + {1'b0, mant}) > 4'd8) eb = 3'(4'd8 - {1'b0, mant});
      return eb;
   endfunction

   // largest legal code, 2^(eb+mb) - 1
   function automatic logic [CODE_W:0] max_code(input cfg_type cfg);
      logic [3:0] total;
      total = {1'b0, cfg.exp_bits} + {1'b0, cfg.mant_bits};
      return (9'd1 << total) - 9'd1;
   endfunction

   // base - 1, the mantissa field mask
   function automatic logic [CODE_W-1:0] mant_mask(input cfg_type cfg);
      return (8'd1 << cfg.mant_bits) - 8'd1;
   endfunction

endpackage

`default_nettype wire

[design/emf_if.sv]
// emf_req_if and emf_rsp_if: valid/ready channels of the codec.
// Depends on emf_pkg for field widths.
`default_nettype none

interface emf_req_if import emf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [FRAME_W-1:0] frame_count;
   logic [CODE_W-1:0]  code_in;

   modport source (output valid, req_type, frame_count, code_in, input ready);
   modport sink   (input valid, req_type, frame_count, code_in, output ready);
endinterface

interface emf_rsp_if import emf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  code_out;
   logic [FRAME_W-1:0] frame_out;
   logic               saturated;
   logic               code_error;

   modport source (output valid, code_out, frame_out, saturated, code_error,
                   input ready);
   modport sink   (input valid, code_out, frame_out, saturated, code_error,
                   output ready);
endinterface

`default_nettype wire

[design/emf_encode.sv]
// emf_encode: frame count to exponent/mantissa code, combinational.
// Depends on emf_pkg.
`default_nettype none

module emf_encode import emf_pkg::*; (
   input  cfg_type             cfg,
   input  logic [FRAME_W-1:0]  frame_count,
   output logic [CODE_W-1:0]   code,
   output logic                sat
);

   logic [FRAME_W:0]   base;
   logic [FRAME_W:0]   biased;
   logic [4:0]         msb;
   logic [4:0]         exp_val;
   logic [4:0]         max_exp;
   logic [FRAME_W:0]   shifted;
   logic [CODE_W-1:0]  mant;
   logic [CODE_W:0]    max_c;

   // biased count and leading-one position
   always_comb begin
      base   = 17'd1 << cfg.mant_bits;
      biased = {1'b0, frame_count} + base;
      msb    = 5'd0;
      for (int i = 0; i <= FRAME_W; i++) begin
         if (biased[i]) msb = 5'(i);
      end
   end

   // exponent, mantissa and saturation to the maximum code
   always_comb begin
      exp_val = msb - {2'b00, cfg.mant_bits};
      max_exp = (5'd1 << cfg.exp_bits) - 5'd1;
      max_c   = max_code(cfg);
      shifted = biased >> exp_val;
      mant    = shifted[CODE_W-1:0] & mant_mask(cfg);
      if (exp_val > max_exp) begin
         code = max_c[CODE_W-1:0];
         sat  = 1'b1;
      end else begin
         code = (8'(exp_val) << cfg.mant_bits) | mant;
         sat  = 1'b0;
      end
   end

endmodule

`default_nettype wire

[design/emf_decode.sv]
// emf_decode: exponent/mantissa code to frame count, combinational.
// Depends on emf_pkg.
`default_nettype none

module emf_decode import emf_pkg::*; (
   input  cfg_type             cfg,
   input  logic [CODE_W-1:0]   code_in,
   output logic [FRAME_W-1:0]  frame,
   output logic                sat,
   output logic                err
);

   logic [CODE_W:0]    max_c;
   logic [CODE_W-1:0]  mant;
   logic [CODE_W-1:0]  exp_wide;
   logic [3:0]         exp_val;
   logic [CODE_W:0]    base;
   logic [CODE_W:0]    sig;
   logic [23:0]        value;

   // split the code and rebuild the count
   always_comb begin
      max_c    = max_code(cfg);
      base     = 9'd1 << cfg.mant_bits;
      mant     = code_in & mant_mask(cfg);
      exp_wide = code_in >> cfg.mant_bits;
      exp_val  = exp_wide[3:0];
      sig      = base + {1'b0, mant};
      value    = (24'(sig) << exp_val) - 24'(base);
   end

   // range checks
   always_comb begin
      frame = '0;
      sat   = 1'b0;
      err   = 1'b0;
      if ({1'b0, code_in} > max_c) begin
         err = 1'b1;
      end else if (value > 24'd65535) begin
         frame = 16'hffff;
         sat   = 1'b1;
      end else begin
         frame = value[FRAME_W-1:0];
      end
   end

endmodule

`default_nettype wire

[design/exponent_mantissa_frame_codec.sv]
// Exponent/mantissa frame codec: a request passes the input register, then the
// result register, before the earliest result transfer. Throughput one item per
// cycle while the result is not stalled; the encode leading-one detect and decode
// shift sit between the two registers. A stalled result holds the result
// register while the input register still takes one more item. Synchronous
// active-high reset clears both valid flags and loads the width registers with 2 and 6.
`default_nettype none

module exponent_mantissa_frame_codec import emf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   emf_req_if.sink           req_bus,
   emf_rsp_if.source         rsp_bus
);

   logic [CFG_W-1:0]   exp_raw_ff, exp_raw_in;
   logic [CFG_W-1:0]   mant_ff, mant_in;
   cfg_type            cfg;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_type_ff, s1_type_in;
   logic [FRAME_W-1:0] s1_frame_ff, s1_frame_in;
   logic [CODE_W-1:0]  s1_code_ff, s1_code_in;

   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   logic               advance;
   logic               req_xfer;
   logic [CODE_W-1:0]  enc_code;
   logic               enc_sat;
   logic [FRAME_W-1:0] dec_frame;
   logic               dec_sat;
   logic               dec_err;

   // width registers
   always_comb begin
      exp_raw_in = exp_raw_ff;
      mant_in    = mant_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_EXP_BITS:  exp_raw_in = csr_wdata;
            CSR_MANT_BITS: mant_in    = csr_wdata;
            default:       exp_raw_in = exp_raw_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_raw_ff <= EXP_BITS_RST;
         mant_ff    <= MANT_BITS_RST;
      end else begin
         exp_raw_ff <= exp_raw_in;
         mant_ff    <= mant_in;
      end
   end

   assign cfg.mant_bits = mant_ff;
   assign cfg.exp_bits  = eff_exp(exp_raw_ff, mant_ff);

   // handshake
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_xfer      = req_bus.valid && req_bus.ready;

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_type_in  = s1_type_ff;
      s1_frame_in = s1_frame_ff;
      s1_code_in  = s1_code_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         s1_type_in  = req_bus.req_type;
         s1_frame_in = req_bus.frame_count;
         s1_code_in  = req_bus.code_in;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_type_ff  <= s1_type_in;
      s1_frame_ff <= s1_frame_in;
      s1_code_ff  <= s1_code_in;
   end

   // codec datapaths
   emf_encode u_encode (
      .cfg         (cfg),
      .frame_count (s1_frame_ff),
      .code        (enc_code),
      .sat         (enc_sat)
   );

   emf_decode u_decode (
      .cfg     (cfg),
      .code_in (s1_code_ff),
      .frame   (dec_frame),
      .sat     (dec_sat),
      .err     (dec_err)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         if (s1_type_ff == REQ_DECODE) begin
            out_in.code_out   = '0;
            out_in.frame_out  = dec_frame;
            out_in.saturated  = dec_sat;
            out_in.code_error = dec_err;
         end else begin
            out_in.code_out   = enc_code;
            out_in.frame_out  = '0;
            out_in.saturated  = enc_sat;
            out_in.code_error = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.code_out   = out_ff.code_out;
   assign rsp_bus.frame_out  = out_ff.frame_out;
   assign rsp_bus.saturated  = out_ff.saturated;
   assign rsp_bus.code_error = out_ff.code_error;

endmodule

`default_nettype wire

[design/emf_checker.sv]
// emf_checker: port-level assertions for the codec top level, and the bind
// that attaches it. Depends on emf_pkg and exponent_mantissa_frame_codec.
`default_nettype none

module emf_checker import emf_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [CODE_W-1:0]  rsp_code_out,
   input logic [FRAME_W-1:0] rsp_frame_out,
   input logic               rsp_saturated,
   input logic               rsp_code_error
);

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_out)
         && $stable(rsp_frame_out) && $stable(rsp_saturated)
         && $stable(rsp_code_error))
      else $error("stalled result changed");

   // a bad code yields an all-zero result with no clamp
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_error |-> rsp_code_out == '0 && rsp_frame_out == '0
         && !rsp_saturated)
      else $error("code error with nonzero result");

   // encode and decode results never mix
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_out != '0 |-> rsp_frame_out == '0 && !rsp_code_error)
      else $error("code and count both set");

endmodule

bind exponent_mantissa_frame_codec emf_checker u_emf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_code_out   (rsp_bus.code_out),
   .rsp_frame_out  (rsp_bus.frame_out),
   .rsp_saturated  (rsp_bus.saturated),
   .rsp_code_error (rsp_bus.code_error)
);

`default_nettype wire
